// File: hdl/binary_grid_neighbor_smoothing_top_macros.svh
// Assertion macros for the grid smoothing block.
// Both macros sample on clk_i and are off while rst_ni is low.
`ifndef BINARY_GRID_NEIGHBOR_SMOOTHING_TOP_MACROS_SVH
`define BINARY_GRID_NEIGHBOR_SMOOTHING_TOP_MACROS_SVH
`ifndef SYNTH
`define BGNS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BGNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BGNS_ASSERT(label, prop, msg)
`define BGNS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/bgns_pkg.sv
package bgns_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int STEP_W = $clog2(MAX_ROWS + 2);
  localparam int CFG_W  = 7;
  localparam int CNT_W  = 4;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_GRID_ROWS  = 2'd0,
    CFG_GRID_COLS  = 2'd1,
    CFG_THRESHOLD  = 2'd2,
    CFG_PASS_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS
  } seq_state_e;

  typedef struct packed {
    logic             busy;
    logic             clr_we;
    logic [ROW_W-1:0] clr_row;
    logic [ROW_W-1:0] rd_row;
    logic             bel_ok;
    logic [ROW_W-1:0] bel_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic             shift;
  } seq_ctrl_t;

  // Zero acts as one, anything past the array size acts as the array size.
  function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [RCNT_W-1:0] r;
    if (v == '0) begin
      r = RCNT_W'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = RCNT_W'(MAX_ROWS);
    end else begin
      r = RCNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [CCNT_W-1:0] r;
    if (v == '0) begin
      r = CCNT_W'(1);
    end else if (int'(v) > MAX_COLS) begin
      r = CCNT_W'(MAX_COLS);
    end else begin
      r = CCNT_W'(v);
    end
    return r;
  endfunction

endpackage

// File: hdl/bgns_ram.sv
module bgns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when both ports hit the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bgns_row_calc.sv
module bgns_row_calc import bgns_pkg::*; (
  input  row_t             up_i,
  input  row_t             mid_i,
  input  row_t             down_i,
  input  logic [CNT_W-1:0] thr_i,
  input  row_t             keep_i,
  output row_t             row_o
);

  logic [MAX_COLS+1:0] up_p;
  logic [MAX_COLS+1:0] mid_p;
  logic [MAX_COLS+1:0] dn_p;
  logic [CNT_W-1:0]    cnt [MAX_COLS];

  // Pad one air column on each side; column c sits at bit c+1.
  assign up_p  = {1'b0, up_i, 1'b0};
  assign mid_p = {1'b0, mid_i, 1'b0};
  assign dn_p  = {1'b0, down_i, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt[c] = CNT_W'(up_p[c]) + CNT_W'(up_p[c+1]) + CNT_W'(up_p[c+2])
             + CNT_W'(mid_p[c]) + CNT_W'(mid_p[c+2])
             + CNT_W'(dn_p[c]) + CNT_W'(dn_p[c+1]) + CNT_W'(dn_p[c+2]);
      row_o[c] = keep_i[c] && (cnt[c] >= thr_i);
    end
  end

endmodule

// File: hdl/bgns_seq.sv
module bgns_seq import bgns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             run_req_i,
  input  logic             run_ack_i,
  input  logic [CNT_W-1:0] pass_count_i,
  output seq_ctrl_t        ctrl_o,
  output logic             cur_bank_o,
  output logic             run_done_o
);

  seq_state_e        state_q, state_d;
  logic [ROW_W-1:0]  clr_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  left_q;
  logic              cur_q;
  logic              done_q;
  logic              step_end;
  logic              start;
  logic [STEP_W-1:0] bel_full;
  logic [STEP_W-1:0] wr_full;

  assign step_end = (step_q == STEP_W'(MAX_ROWS + 1));
  assign start    = run_req_i && !done_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ROW_W'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && (pass_count_i != '0)) begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        if (step_end && (left_q == CNT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
      left_q  <= '0;
      cur_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (run_ack_i) begin
        done_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ROW_W'(1);
        end
        ST_IDLE: begin
          if (start) begin
            if (pass_count_i == '0) begin
              done_q <= 1'b1;
            end else begin
              left_q <= pass_count_i;
              step_q <= '0;
            end
          end
        end
        ST_PASS: begin
          if (step_end) begin
            // New bank becomes current; go again or finish.
            cur_q  <= ~cur_q;
            step_q <= '0;
            left_q <= left_q - CNT_W'(1);
            if (left_q == CNT_W'(1)) begin
              done_q <= 1'b1;
            end
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign bel_full = step_q - STEP_W'(1);
  assign wr_full  = step_q - STEP_W'(2);

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.busy    = (state_q != ST_IDLE);
    ctrl_o.clr_we  = (state_q == ST_CLEAR);
    ctrl_o.clr_row = clr_q;
    ctrl_o.rd_row  = step_q[ROW_W-1:0];
    ctrl_o.bel_row = bel_full[ROW_W-1:0];
    ctrl_o.wr_row  = wr_full[ROW_W-1:0];
    case (state_q)
      ST_PASS: begin
        ctrl_o.shift  = 1'b1;
        ctrl_o.bel_ok = (step_q >= STEP_W'(1)) && (step_q <= STEP_W'(MAX_ROWS));
        ctrl_o.wr_en  = (step_q >= STEP_W'(2));
      end
      default: begin
        ctrl_o.shift  = 1'b0;
        ctrl_o.bel_ok = 1'b0;
        ctrl_o.wr_en  = 1'b0;
      end
    endcase
  end

  assign cur_bank_o = cur_q;
  assign run_done_o = done_q;

endmodule

// File: hdl/binary_grid_neighbor_smoothing_top.sv
// Channel  Direction  Handshake                 Word
// in       sink       in_valid_i / in_stall_o   command_i row_index_i col_index_i cell_in_i
// out      source     out_valid_o / out_stall_i cell_out_o status_o
// cfg      sink       cfg_we_i                  cfg_idx_i cfg_data_i
//
// Write and read words go one per cycle when not stalled; the result is registered.
// During a run word each pass streams the grid one row per cycle through the current
// bank's read port and the other bank's write port.
// After reset a sweep clears every row of both banks; in_stall_o is high meanwhile.
// A stalled result holds the output register, then the pending word, then the input.
`include "binary_grid_neighbor_smoothing_top_macros.svh"

module binary_grid_neighbor_smoothing_top import bgns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [5:0]       row_index_i,
  input  logic [5:0]       col_index_i,
  input  logic             cell_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             cell_out_o,
  output logic             status_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0]  grid_rows_q;
  logic [CFG_W-1:0]  grid_cols_q;
  logic [CNT_W-1:0]  thr_q;
  logic [CNT_W-1:0]  pass_count_q;

  logic [RCNT_W-1:0] rows_act;
  logic [CCNT_W-1:0] cols_act;
  row_t              col_mask;
  logic              inside_in;
  logic              in_acc;

  logic              s1_valid_q;
  cmd_e              s1_cmd_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic [COL_W-1:0]  s1_col_q;
  logic              s1_cell_q;
  logic              s1_inside_q;
  logic              s1_adv;

  logic              out_valid_q;
  logic              cell_out_q;
  logic              status_q;

  logic              fwd_valid_q;
  logic [ROW_W-1:0]  fwd_row_q;
  row_t              fwd_data_q;
  logic              fwd_hit;

  seq_ctrl_t         ctrl;
  logic              cur_bank;
  logic              run_done;
  logic              run_req;

  row_t              rdata_a;
  row_t              rdata_b;
  row_t              cur_rd;
  row_t              base;
  row_t              new_row;
  logic              cmd_we;
  logic [ROW_W-1:0]  ram_raddr;
  logic [ROW_W-1:0]  ram_waddr;
  row_t              ram_wdata;
  logic              we_a;
  logic              we_b;

  row_t              up_q;
  row_t              mid_q;
  row_t              below;
  row_t              keep;
  row_t              pass_row;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= CFG_W'(64);
      grid_cols_q  <= CFG_W'(64);
      thr_q        <= CNT_W'(5);
      pass_count_q <= CNT_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_ROWS:  grid_rows_q  <= cfg_data_i;
        CFG_GRID_COLS:  grid_cols_q  <= cfg_data_i;
        CFG_THRESHOLD:  thr_q        <= cfg_data_i[CNT_W-1:0];
        CFG_PASS_COUNT: pass_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_act = clamp_rows(grid_rows_q);
  assign cols_act = clamp_cols(grid_cols_q);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(cols_act));
    end
  end

  assign inside_in = (int'(row_index_i) < int'(rows_act)) &&
                     (int'(col_index_i) < int'(cols_act));

  // Command stage.
  assign run_req    = s1_valid_q && (s1_cmd_q == CMD_RUN);
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i) &&
                      ((s1_cmd_q != CMD_RUN) || run_done);
  assign in_stall_o = ctrl.busy || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q    <= cmd_e'(command_i);
      s1_row_q    <= ROW_W'(row_index_i);
      s1_col_q    <= COL_W'(col_index_i);
      s1_cell_q   <= cell_in_i;
      s1_inside_q <= inside_in;
    end
  end

  // Row read back from the current bank, patched by a just-committed write to the same row.
  assign cur_rd  = cur_bank ? rdata_b : rdata_a;
  assign fwd_hit = fwd_valid_q && (fwd_row_q == s1_row_q);
  assign base    = fwd_hit ? fwd_data_q : cur_rd;

  always_comb begin
    new_row           = base;
    new_row[s1_col_q] = s1_cell_q;
  end

  assign cmd_we = s1_adv && (s1_cmd_q == CMD_WRITE) && s1_inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= cmd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_we) begin
      fwd_row_q  <= s1_row_q;
      fwd_data_q <= new_row;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      cell_out_q <= (s1_cmd_q == CMD_READ) && s1_inside_q && base[s1_col_q];
      status_q   <= ((s1_cmd_q == CMD_WRITE) || (s1_cmd_q == CMD_READ)) && !s1_inside_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;
  assign status_o    = status_q;

  // Pass sequencer.
  bgns_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_req_i    (run_req),
    .run_ack_i    (s1_adv),
    .pass_count_i (pass_count_q),
    .ctrl_o       (ctrl),
    .cur_bank_o   (cur_bank),
    .run_done_o   (run_done)
  );

  // Three-row window: up, mid in registers, below straight from the source bank.
  assign below = (ctrl.bel_ok && (int'(ctrl.bel_row) < int'(rows_act))) ?
                 (cur_rd & col_mask) : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl.shift) begin
      up_q  <= mid_q;
      mid_q <= below;
    end
  end

  assign keep = (int'(ctrl.wr_row) < int'(rows_act)) ? col_mask : '0;

  bgns_row_calc u_row_calc (
    .up_i   (up_q),
    .mid_i  (mid_q),
    .down_i (below),
    .thr_i  (thr_q),
    .keep_i (keep),
    .row_o  (pass_row)
  );

  // Bank ports: clear sweep, pass write to the other bank, or command access.
  assign ram_raddr = ctrl.busy ? ctrl.rd_row : (in_acc ? ROW_W'(row_index_i) : s1_row_q);
  assign ram_waddr = ctrl.clr_we ? ctrl.clr_row : (ctrl.wr_en ? ctrl.wr_row : s1_row_q);
  assign ram_wdata = ctrl.clr_we ? '0 : (ctrl.wr_en ? pass_row : new_row);
  assign we_a      = ctrl.clr_we || (ctrl.wr_en && cur_bank) || (cmd_we && !cur_bank);
  assign we_b      = ctrl.clr_we || (ctrl.wr_en && !cur_bank) || (cmd_we && cur_bank);

  bgns_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_a)
  );

  bgns_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_b)
  );

  `BGNS_ASSERT(a_result_from_pending, $rose(out_valid_q) |-> $past(s1_valid_q), "result without pending word")
  `BGNS_ASSERT(a_done_when_idle, run_done |-> !ctrl.busy, "run reported done while sequencer busy")
  `BGNS_ASSERT(a_no_cmd_write_busy, !(cmd_we && ctrl.busy), "cell write during pass or clear")
  `BGNS_ASSERT_NEXT(a_pending_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_row_q), "pending word lost")

endmodule

// File: verif/grid_smoothing_checker.sv
module grid_smoothing_checker import bgns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       command_i,
  input  logic [5:0]       row_index_i,
  input  logic [5:0]       col_index_i,
  input  logic             cell_in_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             cell_out_i,
  input  logic             status_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               mismatch_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic cell_out;
    logic status;
  } cell_result_t;

  // Two grid banks, one of them live, plus the register file as last written.
  row_t             grid_bank [2][MAX_ROWS];
  logic             live_bank;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [3:0]       stone_thr_reg;
  logic [3:0]       passes_reg;

  cell_result_t result_q [$];
  int           mismatches;

  // Zero means one row or column, anything past the array means the array.
  function automatic int used_extent(logic [CFG_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void smooth_grid();
    row_t fresh [MAX_ROWS];
    int   rows;
    int   cols;
    int   stones;
    int   nr;
    int   nc;
    rows = used_extent(rows_reg, MAX_ROWS);
    cols = used_extent(cols_reg, MAX_COLS);
    for (int r = 0; r < MAX_ROWS; r++) fresh[r] = '0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        stones = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
              stones += int'(grid_bank[live_bank][nr][nc]);
            end
          end
        end
        fresh[r][c] = (stones >= int'(stone_thr_reg));
      end
    end
    for (int r = 0; r < MAX_ROWS; r++) grid_bank[~live_bank][r] = fresh[r];
    live_bank = ~live_bank;
  endfunction

  function automatic cell_result_t apply_word(logic [1:0] cmd, logic [5:0] row,
                                              logic [5:0] col, logic stone);
    cell_result_t res;
    logic         in_grid;
    res     = '0;
    in_grid = int'(row) < used_extent(rows_reg, MAX_ROWS)
           && int'(col) < used_extent(cols_reg, MAX_COLS);
    case (cmd)
      CMD_WRITE: begin
        if (in_grid) grid_bank[live_bank][row][col] = stone;
        else res.status = 1'b1;
      end
      CMD_RUN: begin
        repeat (int'(passes_reg)) smooth_grid();
      end
      CMD_READ: begin
        if (in_grid) res.cell_out = grid_bank[live_bank][row][col];
        else res.status = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t want;
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < MAX_ROWS; r++) grid_bank[b][r] = '0;
      end
      live_bank     = 1'b0;
      rows_reg      = CFG_W'(MAX_ROWS);
      cols_reg      = CFG_W'(MAX_COLS);
      stone_thr_reg = 4'd5;
      passes_reg    = 4'd4;
      result_q.delete();
      mismatches    = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_ROWS:  rows_reg      = cfg_data_i;
          CFG_GRID_COLS:  cols_reg      = cfg_data_i;
          CFG_THRESHOLD:  stone_thr_reg = cfg_data_i[3:0];
          CFG_PASS_COUNT: passes_reg    = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        result_q = {result_q, apply_word(command_i, row_index_i, col_index_i, cell_in_i)};
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("checker: result word with nothing pending, cell %0d status %0d",
                     cell_out_i, status_i);
          end
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (cell_out_i !== want.cell_out || status_i !== want.status) begin
            if (mismatches < 10) begin
              $display("checker: expected cell %0d status %0d, got cell %0d status %0d",
                       want.cell_out, want.status, cell_out_i, status_i);
            end
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o        <= result_q.size();
    end
  end

endmodule

// File: verif/tb.sv
module tb;
  import bgns_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         QUIET_LIMIT   = 5000;
  localparam int         SETTLE_CYCLES = 2 * (MAX_ROWS + 2);
  localparam int         RANDOM_WORDS  = 700;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [1:0]       command     = '0;
  logic [5:0]       row_index   = '0;
  logic [5:0]       col_index   = '0;
  logic             cell_in     = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic             cell_out;
  logic             status;
  logic             cfg_we      = 1'b0;
  logic [1:0]       cfg_idx     = '0;
  logic [CFG_W-1:0] cfg_data    = '0;

  int mismatches;
  int pending_results;
  int send_idle_pct = 26;
  int recv_idle_pct = 59;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  binary_grid_neighbor_smoothing_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .row_index_i (row_index),
    .col_index_i (col_index),
    .cell_in_i   (cell_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .cell_out_o  (cell_out),
    .status_o    (status),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  grid_smoothing_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .row_index_i      (row_index),
    .col_index_i      (col_index),
    .cell_in_i        (cell_in),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .cell_out_i       (cell_out),
    .status_i         (status),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending_results)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[binary_grid_neighbor_smoothing_top] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Valid stays high from one word to the next unless an idle gap is drawn.
  task automatic send_word(logic [1:0] cmd, logic [5:0] row, logic [5:0] col, logic stone);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    row_index <= row;
    col_index <= col;
    cell_in   <= stone;
    do @(posedge clk_i); while (in_stall);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                          logic [CFG_W-1:0] thr, logic [CFG_W-1:0] passes);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_GRID_ROWS;
    cfg_data <= rows;
    @(posedge clk_i);
    cfg_idx  <= CFG_GRID_COLS;
    cfg_data <= cols;
    @(posedge clk_i);
    cfg_idx  <= CFG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk_i);
    cfg_idx  <= CFG_PASS_COUNT;
    cfg_data <= passes;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int span(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_ROWS) return MAX_ROWS;
    return int'(v);
  endfunction

  // Mostly inside the grid in use, now and then anywhere in the address space.
  function automatic logic [5:0] pick_coord(int used);
    if ($urandom_range(9, 0) == 0) return 6'($urandom);
    return 6'($urandom_range(used - 1, 0));
  endfunction

  // Fill a pattern, smooth it, then probe it; a few stray words go in between.
  task automatic smooth_phase(int rows_used, int cols_used);
    int density;
    int fills;
    density = $urandom_range(85, 15);
    if (rows_used * cols_used <= 48) begin
      for (int r = 0; r < rows_used; r++) begin
        for (int c = 0; c < cols_used; c++) begin
          send_word(CMD_WRITE, 6'(r), 6'(c), $urandom_range(99, 0) < density);
        end
      end
    end else begin
      fills = $urandom_range(40, 12);
      repeat (fills) begin
        send_word(CMD_WRITE, pick_coord(rows_used), pick_coord(cols_used),
                  $urandom_range(99, 0) < density);
      end
    end
    repeat ($urandom_range(3, 0)) begin
      send_word(2'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
    end
    repeat ($urandom_range(2, 1)) begin
      send_word(CMD_RUN, 6'($urandom), 6'($urandom), 1'($urandom));
      repeat ($urandom_range(16, 6)) begin
        send_word(CMD_READ, pick_coord(rows_used), pick_coord(cols_used), 1'($urandom));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] rows_v;
    logic [CFG_W-1:0] cols_v;
    logic [CFG_W-1:0] thr_v;
    logic [CFG_W-1:0] passes_v;
    int               phase_no;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 64 by 64, threshold 5, four passes.
    send_word(CMD_READ, 6'd0, 6'd0, 1'b1);
    send_word(CMD_READ, 6'd63, 6'd63, 1'b0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) send_word(CMD_WRITE, 6'(r), 6'(c), 1'b1);
    end
    send_word(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    send_word(CMD_WRITE, 6'd63, 6'd0, 1'b1);
    send_word(CMD_WRITE, 6'd0, 6'd63, 1'b1);
    send_word(CMD_WRITE, 6'd0, 6'd63, 1'b0);
    send_word(CMD_UNUSED, 6'd63, 6'd63, 1'b1);
    send_word(CMD_READ, 6'd1, 6'd1, 1'b0);
    send_word(CMD_RUN, 6'd0, 6'd0, 1'b0);
    send_word(CMD_READ, 6'd1, 6'd1, 1'b0);
    send_word(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_word(CMD_READ, 6'd0, 6'd1, 1'b0);
    send_word(CMD_READ, 6'd63, 6'd63, 1'b0);
    drain();

    // Coordinates past a small grid are flagged.
    set_grid(7'd2, 7'd2, 7'd5, 7'd4);
    send_word(CMD_WRITE, 6'd2, 6'd0, 1'b1);
    send_word(CMD_READ, 6'd0, 6'd2, 1'b0);
    send_word(CMD_READ, 6'd1, 6'd1, 1'b0);
    drain();

    words_sent = 0;
    phase_no   = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent < RANDOM_WORDS / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 59;
      end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase_no)
        0: begin rows_v = 7'd0;   cols_v = 7'd0;   thr_v = 7'd0;   passes_v = 7'd1;  end
        1: begin rows_v = 7'd127; cols_v = 7'd127; thr_v = 7'd9;   passes_v = 7'd15; end
        2: begin rows_v = 7'd64;  cols_v = 7'd64;  thr_v = 7'h7F;  passes_v = 7'h70; end
        3: begin rows_v = 7'd1;   cols_v = 7'd64;  thr_v = 7'd1;   passes_v = 7'd3;  end
        4: begin rows_v = 7'd64;  cols_v = 7'd1;   thr_v = 7'd2;   passes_v = 7'd2;  end
        5: begin rows_v = 7'd3;   cols_v = 7'd3;   thr_v = 7'd3;   passes_v = 7'd15; end
        default: begin
          rows_v = ($urandom_range(9, 0) == 0) ? 7'($urandom) : 7'($urandom_range(12, 1));
          cols_v = ($urandom_range(9, 0) == 0) ? 7'($urandom) : 7'($urandom_range(12, 1));
          thr_v  = {3'($urandom), ($urandom_range(9, 0) == 0) ?
                    4'($urandom_range(15, 10)) : 4'($urandom_range(9, 0))};
          passes_v = {3'($urandom), ($urandom_range(99, 0) < 85) ?
                      4'($urandom_range(4, 0)) : 4'($urandom_range(15, 5))};
        end
      endcase
      set_grid(rows_v, cols_v, thr_v, passes_v);
      smooth_phase(span(rows_v), span(cols_v));
      drain();
      phase_no++;
    end

    if (mismatches == 0 && pending_results == 0) begin
      $display("[binary_grid_neighbor_smoothing_top] OK");
    end else begin
      $display("[binary_grid_neighbor_smoothing_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bgns_pkg.sv
hdl/bgns_ram.sv
hdl/bgns_row_calc.sv
hdl/bgns_seq.sv
hdl/binary_grid_neighbor_smoothing_top.sv
verif/grid_smoothing_checker.sv
verif/tb.sv
